// File: rtl/core/assert_macros.svh
// assertion helpers shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion sampled on clk, switched off while rstn is low
`define ASSERT_CLK_RST(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed: lbl");

// concurrent assertion sampled on clk, active during reset as well
`define ASSERT_CLK(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed: lbl");

`endif

// File: rtl/core/phr_pkg.sv
package phr_pkg;

  // palette size; indexes at or above it are never recolored
  localparam int unsigned PaletteEntries = 256;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned HueW    = 17;  // 360 * hue code, up to 91800
  localparam int unsigned RatioW  = 15;  // numerator and divisor, up to 30600
  localparam int unsigned RemW    = ChanW + RatioW;
  localparam int unsigned QuoW    = ChanW;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [HueW-1:0] HueScale = 17'd360;
  localparam logic [HueW-1:0] Sec1 = 17'd15300;
  localparam logic [HueW-1:0] Sec2 = 17'd30600;
  localparam logic [HueW-1:0] Sec3 = 17'd45900;
  localparam logic [HueW-1:0] Sec4 = 17'd61200;
  localparam logic [HueW-1:0] Sec5 = 17'd76500;
  localparam logic [HueW-1:0] Sec6 = 17'd91800;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HUE_CODE    = 2'd0,
    CFG_RANGE_FIRST = 2'd1,
    CFG_RANGE_LAST  = 2'd2
  } cfg_reg_e;

  // hue sector: channel that takes the maximum, then the one taking the mix
  typedef enum logic [2:0] {
    SEC_RG, SEC_GR, SEC_GB, SEC_BG, SEC_BR, SEC_RB
  } sector_e;

  typedef struct packed {
    logic [ChanW-1:0] hue_code;
    logic [ChanW-1:0] range_first;
    logic [ChanW-1:0] range_last;
  } cfg_t;

  typedef struct packed {
    logic [ChanW-1:0] index;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             hit;
    logic [ChanW-1:0] mx;
    logic [ChanW-1:0] mn;
    sector_e          sector;
  } pix_t;

  typedef struct packed {
    pix_t              pix;
    logic [RemW-1:0]   rem;
    logic [RatioW-1:0] den;
    logic [QuoW-1:0]   quo;
  } div_t;

endpackage

// File: rtl/core/phr_front.sv
module phr_front import phr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ChanW-1:0] index_i,
  input  logic [ChanW-1:0] red_i,
  input  logic [ChanW-1:0] green_i,
  input  logic [ChanW-1:0] blue_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output div_t             out_o
);

  localparam logic AllInPalette = (PaletteEntries >= 256);

  logic [HueW-1:0]   hue;
  logic [RatioW-1:0] num, den;
  sector_e           sector;
  logic [ChanW-1:0]  mx, mn;
  logic              in_pal;
  pix_t              pix;

  logic              a_valid_q, a_ready;
  pix_t              a_pix_q;
  logic [ChanW-1:0]  a_diff_q;
  logic [RatioW-1:0] a_num_q, a_den_q;
  logic              b_valid_q, b_ready;
  div_t              b_q;

  assign hue = 17'(cfg_i.hue_code) * HueScale;

  // sector and exact hue ratio, both set by the hue code alone
  always_comb begin
    if (hue < Sec1) begin
      sector = SEC_RG;
      num    = RatioW'(hue);
      den    = RatioW'(Sec2 - hue);
    end else if (hue <= Sec2) begin
      sector = SEC_GR;
      num    = RatioW'(Sec2 - hue);
      den    = RatioW'(hue);
    end else if (hue < Sec3) begin
      sector = SEC_GB;
      num    = RatioW'(hue - Sec2);
      den    = RatioW'(Sec4 - hue);
    end else if (hue <= Sec4) begin
      sector = SEC_BG;
      num    = RatioW'(Sec4 - hue);
      den    = RatioW'(hue - Sec2);
    end else if (hue < Sec5) begin
      sector = SEC_BR;
      num    = RatioW'(hue - Sec4);
      den    = RatioW'(Sec6 - hue);
    end else begin
      sector = SEC_RB;
      num    = RatioW'(Sec6 - hue);
      den    = RatioW'(hue - Sec4);
    end
  end

  always_comb begin
    mx = red_i;
    mn = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
  end

  assign in_pal = AllInPalette || (32'(index_i) < PaletteEntries);

  always_comb begin
    pix.index  = index_i;
    pix.red    = red_i;
    pix.green  = green_i;
    pix.blue   = blue_i;
    pix.hit    = in_pal && (index_i >= cfg_i.range_first) && (index_i <= cfg_i.range_last);
    pix.mx     = mx;
    pix.mn     = mn;
    pix.sector = sector;
  end

  assign b_ready    = !b_valid_q || out_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= in_valid_i;
      if (b_ready) b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      a_pix_q  <= pix;
      a_diff_q <= mx - mn;
      a_num_q  <= num;
      a_den_q  <= den;
    end
    if (b_ready && a_valid_q) begin
      b_q.pix <= a_pix_q;
      b_q.rem <= RemW'(a_diff_q) * RemW'(a_num_q);
      b_q.den <= a_den_q;
      b_q.quo <= '0;
    end
  end

  assign out_valid_o = b_valid_q;
  assign out_o       = b_q;

endmodule

// File: rtl/core/phr_div_cell.sv
module phr_div_cell import phr_pkg::*; #(
  parameter int unsigned Bit = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  div_t in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output div_t out_o
);

  logic [RemW-1:0] den_sh;
  div_t            step;
  logic            valid_q;
  div_t            data_q;

  assign den_sh = RemW'(in_i.den) << Bit;

  // one restoring step: quotient bit Bit
  always_comb begin
    step = in_i;
    if (in_i.rem >= den_sh) begin
      step.rem      = in_i.rem - den_sh;
      step.quo[Bit] = 1'b1;
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) data_q <= step;
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule

// File: rtl/core/phr_back.sv
module phr_back import phr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  div_t             in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ChanW-1:0] index_o,
  output logic [ChanW-1:0] red_o,
  output logic [ChanW-1:0] green_o,
  output logic [ChanW-1:0] blue_o,
  output logic             recolored_o
);

  logic [ChanW-1:0] mid, mx, mn;
  logic [ChanW-1:0] red_d, green_d, blue_d;
  logic             valid_q;
  logic [ChanW-1:0] index_q, red_q, green_q, blue_q;
  logic             recolored_q;

  assign mx  = in_i.pix.mx;
  assign mn  = in_i.pix.mn;
  assign mid = mn + ChanW'(in_i.quo);

  always_comb begin
    red_d   = in_i.pix.red;
    green_d = in_i.pix.green;
    blue_d  = in_i.pix.blue;
    if (in_i.pix.hit) begin
      case (in_i.pix.sector)
        SEC_RG: begin red_d = mx; green_d = mid; blue_d = mn; end
        SEC_GR: begin red_d = mid; green_d = mx; blue_d = mn; end
        SEC_GB: begin red_d = mn; green_d = mx; blue_d = mid; end
        SEC_BG: begin red_d = mn; green_d = mid; blue_d = mx; end
        SEC_BR: begin red_d = mid; green_d = mn; blue_d = mx; end
        SEC_RB: begin red_d = mx; green_d = mn; blue_d = mid; end
        default: begin red_d = mx; green_d = mn; blue_d = mid; end
      endcase
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      index_q     <= in_i.pix.index;
      red_q       <= red_d;
      green_q     <= green_d;
      blue_q      <= blue_d;
      recolored_q <= in_i.pix.hit;
    end
  end

  assign out_valid_o = valid_q;
  assign index_o     = index_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;
  assign recolored_o = recolored_q;

endmodule

// File: rtl/core/palette_hue_replace_unit.sv
// path: an input transfer passes 2 front stages, 8 divider cells and
//   1 output register; a result is held there while the output is stalled
// throughput: one entry per cycle unless the output stalls; cells refill as they empty
// reset: rst_ni async active low clears all stage valid bits and sets
//   hue_code = 0, range_first = 0, range_last = 255
module palette_hue_replace_unit import phr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ChanW-1:0]   cfg_data_i,
  // input stream
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [31:0]        s_axis_tdata_i,  // entry_index, red_in, green_in, blue_in
  // result stream
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [31:0]        m_axis_tdata_o,  // out_index, red_out, green_out, blue_out
  output logic               m_axis_tuser_o   // recolored
);

  localparam int unsigned Cells = QuoW;

  logic [ChanW-1:0] hue_code_q, range_first_q, range_last_q;
  cfg_t             cfg;

  // handshake and data between neighbors of the chain; slot 0 feeds the first cell
  logic             chain_valid [Cells+1];
  logic             chain_ready [Cells+1];
  div_t             chain_data  [Cells+1];

  // configuration is always taken; an unknown index is dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_code_q    <= '0;
      range_first_q <= '0;
      range_last_q  <= '1;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_HUE_CODE:    hue_code_q    <= cfg_data_i;
        CFG_RANGE_FIRST: range_first_q <= cfg_data_i;
        CFG_RANGE_LAST:  range_last_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg.hue_code    = hue_code_q;
  assign cfg.range_first = range_first_q;
  assign cfg.range_last  = range_last_q;

  // classify the entry, pick the hue sector, then form d * num
  phr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .index_i     (s_axis_tdata_i[7:0]),
    .red_i       (s_axis_tdata_i[15:8]),
    .green_i     (s_axis_tdata_i[23:16]),
    .blue_i      (s_axis_tdata_i[31:24]),
    .out_valid_o (chain_valid[0]),
    .out_ready_i (chain_ready[0]),
    .out_o       (chain_data[0])
  );

  // divider chain: each cell settles one quotient bit, msb first, and hands
  // the partial remainder to its neighbor
  for (genvar g = 0; g < Cells; g++) begin : g_cell
    phr_div_cell #(
      .Bit (Cells - 1 - g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (chain_valid[g]),
      .in_ready_o  (chain_ready[g]),
      .in_i        (chain_data[g]),
      .out_valid_o (chain_valid[g+1]),
      .out_ready_i (chain_ready[g+1]),
      .out_o       (chain_data[g+1])
    );
  end

  // place max, min and mixed channel by sector; output register
  phr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (chain_valid[Cells]),
    .in_ready_o  (chain_ready[Cells]),
    .in_i        (chain_data[Cells]),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .index_o     (m_axis_tdata_o[7:0]),
    .red_o       (m_axis_tdata_o[15:8]),
    .green_o     (m_axis_tdata_o[23:16]),
    .blue_o      (m_axis_tdata_o[31:24]),
    .recolored_o (m_axis_tuser_o)
  );

endmodule

// File: rtl/core/phr_checker.sv
`include "assert_macros.svh"

module phr_checker import phr_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o
);

  logic        out_stall;
  logic [32:0] out_beat;

  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign out_beat  = {m_axis_tuser_o, m_axis_tdata_o};

  // a stalled result holds
  `ASSERT_CLK_RST(a_out_hold, clk_i, rst_ni, out_stall |=> m_axis_tvalid_o && $stable(out_beat))

  // an empty or draining output stage never blocks the input side
  `ASSERT_CLK_RST(a_ready_flow, clk_i, rst_ni, !out_stall |-> s_axis_tready_o)

  // every configuration write is taken at once
  `ASSERT_CLK_RST(a_cfg_taken, clk_i, rst_ni, cfg_valid_i |-> cfg_ready_o)

  // no result right after reset is released
  `ASSERT_CLK(a_reset_empty, clk_i, $rose(rst_ni) |-> !m_axis_tvalid_o)

endmodule

bind palette_hue_replace_unit phr_checker u_phr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .cfg_valid_i     (cfg_valid_i),
  .cfg_ready_o     (cfg_ready_o),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
